// ===== src/zmie_pkg.sv =====
`default_nettype none

package zmie_pkg;

  localparam int NUM_OPS   = 4;
  localparam int NUM_SLOTS = 11;

  // byte slots of one instruction, in emission order
  localparam int SLOT_HDR0 = 0;
  localparam int SLOT_HDR1 = 1;
  localparam int SLOT_TYPE = 2;
  localparam int SLOT_OPS  = 3;  // operand i: high byte at 3+2i, low byte at 4+2i

  localparam logic [1:0] CMD_ONE = 2'd0;
  localparam logic [1:0] CMD_TWO = 2'd1;
  localparam logic [1:0] CMD_VAR = 2'd2;
  localparam logic [1:0] CMD_EXT = 2'd3;

  localparam logic [1:0] KIND_CONST = 2'd0;
  localparam logic [1:0] KIND_VAR   = 2'd1;
  localparam logic [1:0] KIND_OMIT  = 2'd2;

  localparam logic [1:0] TYPE_LARGE = 2'd0;
  localparam logic [1:0] TYPE_SMALL = 2'd1;
  localparam logic [1:0] TYPE_VAR   = 2'd2;
  localparam logic [1:0] TYPE_OMIT  = 2'd3;

  localparam logic [7:0] EXT_PREFIX = 8'd190;

  typedef struct packed {
    logic                            err;
    logic [NUM_SLOTS-1:0]            mask;
    logic [NUM_SLOTS-1:0][7:0]       bytes;
  } desc_t;

  function automatic logic [1:0] op_type(input logic [15:0] val, input logic [1:0] kind);
    logic [1:0] t;
    if (kind == KIND_VAR) begin
      t = TYPE_VAR;
    end else if (val[15:8] == 8'd0) begin
      t = TYPE_SMALL;
    end else begin
      t = TYPE_LARGE;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/zmie_front.sv =====
`default_nettype none

module zmie_front import zmie_pkg::*; #(
  parameter int MAX_OPERANDS = 4
) (
  input  wire logic [1:0]               command,
  input  wire logic [7:0]               opcode,
  input  wire logic [2:0]               operand_count,
  input  wire logic [NUM_OPS-1:0][15:0] vals,
  input  wire logic [NUM_OPS-1:0][1:0]  kinds,
  output desc_t                         desc
);

  logic [NUM_OPS-1:0]      op_en;
  logic [2:0]              used_count;
  logic [NUM_OPS-1:0][1:0] types;
  logic [7:0]              base;

  always_comb begin
    desc       = '0;
    op_en      = '0;
    used_count = operand_count;
    base       = opcode;
    if (command == CMD_TWO) begin
      used_count = 3'd2;
    end
    for (int i = 0; i < NUM_OPS; i++) begin
      if (3'(i) < used_count && kinds[i] != KIND_OMIT) begin
        types[i] = op_type(vals[i], kinds[i]);
      end else begin
        types[i] = TYPE_OMIT;
      end
    end
    if (opcode[7:6] == 2'b00) begin
      base[5] = 1'b0;
    end else begin
      base[5] = 1'b1;
    end

    unique case (command)
      CMD_ONE: begin
        desc.mask[SLOT_HDR0]  = 1'b1;
        desc.bytes[SLOT_HDR0] = {2'b10, op_type(vals[0], kinds[0]), opcode[3:0]};
        op_en                 = 4'b0001;
      end
      CMD_TWO: begin
        desc.mask[SLOT_HDR0] = 1'b1;
        if (vals[0][15:8] == 8'd0 && vals[1][15:8] == 8'd0) begin
          // long form: both operands one byte whatever the kind
          desc.bytes[SLOT_HDR0]  = {1'b0, kinds[0] == KIND_VAR, kinds[1] == KIND_VAR,
                                    opcode[4:0]};
          desc.mask[SLOT_OPS+1]  = 1'b1;
          desc.bytes[SLOT_OPS+1] = vals[0][7:0];
          desc.mask[SLOT_OPS+3]  = 1'b1;
          desc.bytes[SLOT_OPS+3] = vals[1][7:0];
        end else begin
          desc.bytes[SLOT_HDR0] = {3'b110, opcode[4:0]};
          desc.mask[SLOT_TYPE]  = 1'b1;
          desc.bytes[SLOT_TYPE] = {types[0], types[1], types[2], types[3]};
          for (int i = 0; i < NUM_OPS; i++) begin
            op_en[i] = (types[i] != TYPE_OMIT);
          end
        end
      end
      CMD_VAR, CMD_EXT: begin
        if (32'(operand_count) > MAX_OPERANDS) begin
          desc.err             = 1'b1;
          desc.mask[SLOT_HDR0] = 1'b1;
        end else begin
          desc.mask[SLOT_HDR0] = 1'b1;
          if (command == CMD_VAR) begin
            desc.bytes[SLOT_HDR0] = base | 8'hC0;
          end else begin
            desc.bytes[SLOT_HDR0] = EXT_PREFIX;
            desc.mask[SLOT_HDR1]  = 1'b1;
            desc.bytes[SLOT_HDR1] = opcode;
          end
          desc.mask[SLOT_TYPE]  = 1'b1;
          desc.bytes[SLOT_TYPE] = {types[0], types[1], types[2], types[3]};
          for (int i = 0; i < NUM_OPS; i++) begin
            op_en[i] = (types[i] != TYPE_OMIT);
          end
        end
      end
      default: begin
        desc = '0;
      end
    endcase

    for (int i = 0; i < NUM_OPS; i++) begin
      if (op_en[i]) begin
        desc.mask[SLOT_OPS+2*i+1]  = 1'b1;
        desc.bytes[SLOT_OPS+2*i+1] = vals[i][7:0];
        if (kinds[i] != KIND_VAR && vals[i][15:8] != 8'd0) begin
          desc.mask[SLOT_OPS+2*i]  = 1'b1;
          desc.bytes[SLOT_OPS+2*i] = vals[i][15:8];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/zmie_fifo.sv =====
`default_nettype none

module zmie_fifo import zmie_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire desc_t wr_data,
  output logic       full,
  input  wire logic  rd_en,
  output logic       not_empty,
  output desc_t      rd_data
);

  desc_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/zmie_back.sv =====
`default_nettype none

module zmie_back import zmie_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire desc_t q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] code_byte,
  output logic       last_byte,
  output logic       count_error
);

  logic [NUM_SLOTS-1:0]      cur_mask;
  logic [NUM_SLOTS-1:0][7:0] cur_bytes;
  logic                      cur_err;
  logic [NUM_SLOTS-1:0]      first;
  logic [NUM_SLOTS-1:0]      rest;
  logic [7:0]                sel;
  logic                      emit;

  always_comb begin
    first = cur_mask & (~cur_mask + NUM_SLOTS'(1));
    rest  = cur_mask & ~first;
    sel   = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      sel = sel | (cur_bytes[k] & {8{first[k]}});
    end
  end

  assign emit  = (cur_mask != '0) && (!out_valid || !out_stall);
  // take the next instruction as the current one runs out
  assign q_pop = q_valid && ((cur_mask == '0) || (emit && rest == '0));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bytes <= q_data.bytes;
      cur_err   <= q_data.err;
    end
    if (emit) begin
      code_byte   <= sel;
      last_byte   <= (rest == '0);
      count_error <= cur_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask <= q_data.mask;
      end else if (emit) begin
        cur_mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/zmachine_instruction_encoder_top.sv =====
// Z-machine instruction encoder.
// Input channel: one beat per instruction request (form command, opcode,
// operand count, four operand values and kinds), handshake in_valid/in_stall.
// Output channel: one beat per encoded byte (code_byte, last_byte set on the
// final byte), handshake out_valid/out_stall. A request refused for too many
// operands gives a single beat with count_error and last_byte set.
// A classifier builds a slot list of the instruction's bytes, which waits in
// a two-entry queue; the emitter walks the slots, one byte per cycle while
// out_stall does not hold it. A request's beat is written into the queue,
// then loaded into the emitter's slot register, and its first byte is then
// registered onto code_byte. A request gives 1 to 11 bytes; the emitter loads
// the next request's slots as it emits the current request's last byte.
// in_stall is high during reset and while the queue is full.
// Reset (synchronous, rst high) empties the queue and drops out_valid.
// While out_stall is high the presented byte holds and the emitter waits;
// the queue keeps taking requests until both entries are occupied.
`default_nettype none

module zmachine_instruction_encoder_top import zmie_pkg::*; #(
  parameter int MAX_OPERANDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  opcode,
  input  wire logic [2:0]  operand_count,
  input  wire logic [15:0] first_operand_value,
  input  wire logic [15:0] second_operand_value,
  input  wire logic [15:0] third_operand_value,
  input  wire logic [15:0] fourth_operand_value,
  input  wire logic [1:0]  first_operand_kind,
  input  wire logic [1:0]  second_operand_kind,
  input  wire logic [1:0]  third_operand_kind,
  input  wire logic [1:0]  fourth_operand_kind,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       code_byte,
  output logic             last_byte,
  output logic             count_error
);

  logic [NUM_OPS-1:0][15:0] vals;
  logic [NUM_OPS-1:0][1:0]  kinds;
  desc_t                    in_desc;
  desc_t                    q_data;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;

  assign vals  = {fourth_operand_value, third_operand_value,
                  second_operand_value, first_operand_value};
  assign kinds = {fourth_operand_kind, third_operand_kind,
                  second_operand_kind, first_operand_kind};

  assign in_stall = q_full || rst;

  zmie_front #(
    .MAX_OPERANDS (MAX_OPERANDS)
  ) u_front (
    .command       (command),
    .opcode        (opcode),
    .operand_count (operand_count),
    .vals          (vals),
    .kinds         (kinds),
    .desc          (in_desc)
  );

  zmie_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_valid && !in_stall),
    .wr_data   (in_desc),
    .full      (q_full),
    .rd_en     (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  zmie_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_byte   (code_byte),
    .last_byte   (last_byte),
    .count_error (count_error)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import zmie_pkg::*;

  localparam int MAX_OPERANDS   = 4;
  localparam int DIR_N          = 24;
  localparam int RAND_PER_PHASE = 32;
  localparam int QUIET_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PEND_DEPTH     = 2048;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       opc;
    logic [2:0]       cnt;
    logic [3:0][15:0] val;   // val[0] is the first operand
    logic [3:0][1:0]  kind;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic       count_error;
  } beat_t;

  typedef struct packed {
    req_t            rq;
    logic [1:0]      n_typed;  // 0: bytes come from the encoder model
    beat_t [0:2]     typed;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [7:0]  opcode = '0;
  logic [2:0]  operand_count = '0;
  logic [15:0] first_operand_value = '0;
  logic [15:0] second_operand_value = '0;
  logic [15:0] third_operand_value = '0;
  logic [15:0] fourth_operand_value = '0;
  logic [1:0]  first_operand_kind = '0;
  logic [1:0]  second_operand_kind = '0;
  logic [1:0]  third_operand_kind = '0;
  logic [1:0]  fourth_operand_kind = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  code_byte;
  logic        last_byte;
  logic        count_error;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int failures       = 0;

  // expected beats, written by the stimulus side and read by the checker
  beat_t      pend_mem [PEND_DEPTH];
  int         pend_wr = 0;
  int         pend_rd = 0;
  logic [7:0] enc_buf [NUM_SLOTS];
  int         enc_n = 0;
  row_t       dir_tab [DIR_N];

  zmachine_instruction_encoder_top #(.MAX_OPERANDS(MAX_OPERANDS)) u_top (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .command              (command),
    .opcode               (opcode),
    .operand_count        (operand_count),
    .first_operand_value  (first_operand_value),
    .second_operand_value (second_operand_value),
    .third_operand_value  (third_operand_value),
    .fourth_operand_value (fourth_operand_value),
    .first_operand_kind   (first_operand_kind),
    .second_operand_kind  (second_operand_kind),
    .third_operand_kind   (third_operand_kind),
    .fourth_operand_kind  (fourth_operand_kind),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .code_byte            (code_byte),
    .last_byte            (last_byte),
    .count_error          (count_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- encoder model

  function automatic beat_t bt(input logic [7:0] b, input logic last);
    return beat_t'{code_byte: b, last_byte: last, count_error: 1'b0};
  endfunction

  function automatic void pend_put(input beat_t b);
    pend_mem[pend_wr] = b;
    pend_wr++;
  endfunction

  function automatic void enc_put(input logic [7:0] b);
    enc_buf[enc_n] = b;
    enc_n++;
  endfunction

  function automatic logic [1:0] operand_type(input logic [15:0] v, input logic [1:0] k);
    if (k == KIND_VAR) return TYPE_VAR;
    if (v < 16'd256) return TYPE_SMALL;
    return TYPE_LARGE;
  endfunction

  // variables always take one byte, even with a wide value
  function automatic void enc_operand(input logic [15:0] v, input logic [1:0] k);
    if (k == KIND_VAR || v < 16'd256) begin
      enc_put(v[7:0]);
    end else begin
      enc_put(v[15:8]);
      enc_put(v[7:0]);
    end
  endfunction

  function automatic void enc_typed_list(input req_t r, input int cnt);
    logic [7:0] types;
    bit         omit [4];
    types = '0;
    for (int i = 0; i < 4; i++) begin
      omit[i] = (i >= cnt) || (r.kind[i] == KIND_OMIT);
      types[7-2*i -: 2] = omit[i] ? TYPE_OMIT : operand_type(r.val[i], r.kind[i]);
    end
    enc_put(types);
    for (int i = 0; i < 4; i++) begin
      if (!omit[i]) enc_operand(r.val[i], r.kind[i]);
    end
  endfunction

  function automatic void encode_request(input req_t r);
    logic [7:0] b;
    enc_n = 0;
    if ((r.cmd == CMD_VAR || r.cmd == CMD_EXT) && r.cnt > MAX_OPERANDS) begin
      pend_put(beat_t'{code_byte: 8'h00, last_byte: 1'b1, count_error: 1'b1});
      return;
    end
    case (r.cmd)
      CMD_ONE: begin
        enc_put({2'b10, operand_type(r.val[0], r.kind[0]), r.opc[3:0]});
        enc_operand(r.val[0], r.kind[0]);
      end
      CMD_TWO: begin
        if (r.val[0] < 16'd256 && r.val[1] < 16'd256) begin
          // long form: omitted kinds count as constants here
          b = {3'b000, r.opc[4:0]};
          if (r.kind[0] == KIND_VAR) b[6] = 1'b1;
          if (r.kind[1] == KIND_VAR) b[5] = 1'b1;
          enc_put(b);
          enc_put(r.val[0][7:0]);
          enc_put(r.val[1][7:0]);
        end else begin
          enc_put({3'b110, r.opc[4:0]});
          enc_typed_list(r, 2);
        end
      end
      CMD_VAR: begin
        b = r.opc;
        b[5] = (r.opc[7:6] != 2'b00);
        b[7:6] = 2'b11;
        enc_put(b);
        enc_typed_list(r, r.cnt);
      end
      default: begin
        enc_put(EXT_PREFIX);
        enc_put(r.opc);
        enc_typed_list(r, r.cnt);
      end
    endcase
    for (int i = 0; i < enc_n; i++) begin
      pend_put(bt(enc_buf[i], i == enc_n - 1));
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic row_t mk(input logic [1:0] cmd, input logic [7:0] opc,
                              input logic [2:0] cnt,
                              input logic [15:0] v0, input logic [15:0] v1,
                              input logic [15:0] v2, input logic [15:0] v3,
                              input logic [1:0] k0, input logic [1:0] k1,
                              input logic [1:0] k2, input logic [1:0] k3);
    row_t r;
    r = '0;
    r.rq.cmd  = cmd;
    r.rq.opc  = opc;
    r.rq.cnt  = cnt;
    r.rq.val  = {v3, v2, v1, v0};
    r.rq.kind = {k3, k2, k1, k0};
    return r;
  endfunction

  function automatic row_t mk_err(input logic [1:0] cmd, input logic [2:0] cnt);
    row_t r;
    r = mk(cmd, 8'hA5, cnt, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
           KIND_CONST, KIND_VAR, KIND_OMIT, KIND_CONST);
    r.n_typed  = 2'd1;
    r.typed[0] = beat_t'{code_byte: 8'h00, last_byte: 1'b1, count_error: 1'b1};
    return r;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 255));
      1:       return 16'd255;
      2:       return 16'd256;
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t pick_request();
    req_t r;
    r.cmd = 2'($urandom_range(0, 3));
    r.opc = 8'($urandom);
    r.cnt = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    for (int i = 0; i < 4; i++) begin
      r.val[i]  = pick_value();
      r.kind[i] = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                             : 2'($urandom_range(2, 3));
    end
    return r;
  endfunction

  // holds the beat until taken; in_valid stays high into the next request
  task automatic offer_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command              <= r.cmd;
    opcode               <= r.opc;
    operand_count        <= r.cnt;
    first_operand_value  <= r.val[0];
    second_operand_value <= r.val[1];
    third_operand_value  <= r.val[2];
    fourth_operand_value <= r.val[3];
    first_operand_kind   <= r.kind[0];
    second_operand_kind  <= r.kind[1];
    third_operand_kind   <= r.kind[2];
    fourth_operand_kind  <= r.kind[3];
    in_valid             <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- output check

  always @(posedge clk) begin : byte_check
    beat_t want;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pend_rd == pend_wr) begin
          $error("unexpected beat: code_byte %02h last_byte %0b count_error %0b",
                 code_byte, last_byte, count_error);
          failures++;
        end else begin
          want = pend_mem[pend_rd];
          pend_rd++;
          if (code_byte !== want.code_byte) begin
            $error("code_byte: expected %02h, got %02h", want.code_byte, code_byte);
            failures++;
          end
          if (last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, last_byte);
            failures++;
          end
          if (count_error !== want.count_error) begin
            $error("count_error: expected %0b, got %0b", want.count_error, count_error);
            failures++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : main_seq
    int phase_send [4];
    int phase_stall [4];
    req_t r;
    phase_send  = '{0, 79, 0, 22};
    phase_stall = '{0, 0, 79, 22};

    dir_tab = '{
      mk(CMD_ONE, 8'h00, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_ONE, 8'h0F, 3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_ONE, 8'hFF, 3'd7, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         KIND_VAR, KIND_VAR, KIND_VAR, KIND_VAR),
      mk(CMD_ONE, 8'h05, 3'd0, 16'h1234, 16'h0000, 16'h0000, 16'h0000,
         KIND_OMIT, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_ONE, 8'h07, 3'd0, 16'h0012, 16'h0000, 16'h0000, 16'h0000,
         2'd3, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'h1F, 3'd0, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'h01, 3'd0, 16'h0010, 16'h0020, 16'h0000, 16'h0000,
         KIND_VAR, KIND_VAR, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'hFF, 3'd0, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'h14, 3'd0, 16'hFFFF, 16'h0003, 16'h0000, 16'h0000,
         KIND_VAR, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'h03, 3'd0, 16'h012C, 16'h0005, 16'h0000, 16'h0000,
         KIND_OMIT, KIND_VAR, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'h02, 3'd0, 16'h000A, 16'h0100, 16'h0000, 16'h0000,
         KIND_CONST, KIND_OMIT, KIND_CONST, KIND_CONST),
      mk(CMD_TWO, 8'hE0, 3'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
         2'd3, 2'd3, KIND_CONST, KIND_CONST),
      mk(CMD_VAR, 8'h00, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_VAR, 8'h3F, 3'd4, 16'hFFFF, 16'h8000, 16'h0100, 16'hFFFF,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_VAR, 8'h40, 3'd4, 16'h0011, 16'h0022, 16'h0033, 16'h0044,
         KIND_VAR, KIND_CONST, KIND_OMIT, 2'd3),
      mk(CMD_VAR, 8'hFF, 3'd2, 16'h00FF, 16'h0100, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk_err(CMD_VAR, 3'd5),
      mk_err(CMD_VAR, 3'd7),
      mk(CMD_EXT, 8'h00, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_EXT, 8'hFF, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk_err(CMD_EXT, 3'd6),
      mk(CMD_EXT, 8'h12, 3'd3, 16'h00AB, 16'hABCD, 16'h0007, 16'hFFFF,
         KIND_OMIT, KIND_VAR, KIND_CONST, KIND_CONST),
      mk(CMD_VAR, 8'h80, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
         KIND_CONST, KIND_CONST, KIND_CONST, KIND_CONST),
      mk(CMD_ONE, 8'h0A, 3'd0, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
         KIND_VAR, KIND_CONST, KIND_CONST, KIND_CONST)
    };
    // short form, smallest and largest constant
    dir_tab[0].n_typed = 2'd2;
    dir_tab[0].typed   = {bt(8'h90, 1'b0), bt(8'h00, 1'b1), bt(8'h00, 1'b0)};
    dir_tab[1].n_typed = 2'd3;
    dir_tab[1].typed   = {bt(8'h8F, 1'b0), bt(8'hFF, 1'b0), bt(8'hFF, 1'b1)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      offer_request(dir_tab[i].rq);
      if (dir_tab[i].n_typed != 0) begin
        for (int j = 0; j < dir_tab[i].n_typed; j++) pend_put(dir_tab[i].typed[j]);
      end else begin
        encode_request(dir_tab[i].rq);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        r = pick_request();
        offer_request(r);
        encode_request(r);
      end
    end
    in_valid <= 1'b0;

    while (pend_rd != pend_wr) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
